// File: rtl/ttsd_pkg.sv
// Shared types, constants and the quarter-wave sine ROM for the tremolo/drive block.
// The ROM contents are computed at elaboration; no dependencies.
package ttsd_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned PHASE_BITS  = 24;
  localparam int unsigned SINE_DEPTH  = 256;

  localparam int unsigned SIN_FRAC_W = $clog2(SINE_DEPTH);
  localparam int unsigned ROM_IDX_W  = $clog2(SINE_DEPTH + 1);
  localparam int unsigned SIN_OFF_W  = 17;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LFO_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LFO_DEPTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE2     = 3'd4;

  localparam logic [10:0] DEPTH_MAX = 11'd1024;
  localparam logic [11:0] DRIVE_MAX = 12'd2560;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN,
    ST_XCLAMP,
    ST_WET,
    ST_WETSH,
    ST_MIX,
    ST_MIXSH,
    ST_SQ1,
    ST_CUBE1,
    ST_LIN1,
    ST_F1,
    ST_SQ2,
    ST_CUBE2,
    ST_DRV2,
    ST_G,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    MUL_GAIN,
    MUL_WET,
    MUL_MIX,
    MUL_XX,
    MUL_SQX,
    MUL_LIN,
    MUL_FF,
    MUL_SQF,
    MUL_DRV2
  } mul_sel_e;

  typedef struct packed {
    logic     in_ready;
    logic     ld_s;
    logic     lfo_adv;
    mul_sel_e mul_sel;
    logic     ld_x_gain;
    logic     ld_diff;
    logic     ld_x_mix;
    logic     ld_t;
    logic     ld_f;
    logic     ld_y;
    logic     ld_out;
  } ctrl_t;

  typedef logic [15:0] sine_rom_t [SINE_DEPTH+1];

  localparam logic [63:0] PI_Q30   = 64'd3373259426;
  localparam logic [63:0] SINE_DIV = 64'(2 * SINE_DEPTH);

  function automatic logic [63:0] sine_term(input logic [63:0] t, input logic [63:0] xv);
    logic [63:0] p;
    p = (t * xv) >> 30;
    p = (p * xv) >> 30;
    return p;
  endfunction

  // round(sin(k*pi/(2*depth)) * 32768) by a Taylor series in Q2.30
  function automatic logic [15:0] sine_entry(input int unsigned k);
    logic [63:0]        xv;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    xv   = (64'(k) * PI_Q30) / SINE_DIV;
    term = xv;
    sum  = $signed(xv);
    term = sine_term(term, xv) / 64'd6;
    sum  = sum - $signed(term);
    term = sine_term(term, xv) / 64'd20;
    sum  = sum + $signed(term);
    term = sine_term(term, xv) / 64'd42;
    sum  = sum - $signed(term);
    term = sine_term(term, xv) / 64'd72;
    sum  = sum + $signed(term);
    term = sine_term(term, xv) / 64'd110;
    sum  = sum - $signed(term);
    term = sine_term(term, xv) / 64'd156;
    sum  = sum + $signed(term);
    term = sine_term(term, xv) / 64'd210;
    sum  = sum - $signed(term);
    r = (sum + 64'sd16384) >>> 15;
    if (r < 0) begin
      r = 0;
    end else if (r > 64'sd32768) begin
      r = 64'sd32768;
    end
    return r[15:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k <= int'(SINE_DEPTH); k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// File: rtl/ttsd_mul.sv
// Shared signed multiplier with a registered product.
// Depends on ttsd_pkg for the operand and product widths.
module ttsd_mul import ttsd_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/ttsd_lfo.sv
// Tremolo phase accumulator and quarter-wave sine lookup, registered.
// Depends on ttsd_pkg for the phase width and the sine ROM.
module ttsd_lfo import ttsd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic [PHASE_BITS-1:0] step_i,
  output logic [SIN_OFF_W-1:0]  sin_off_o
);

  localparam logic [SIN_OFF_W-1:0] SIN_BIAS = SIN_OFF_W'(32768);

  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [1:0]            quarter;
  logic [SIN_FRAC_W-1:0] frac;
  logic [ROM_IDX_W-1:0]  idx;
  logic [15:0]           rom_val;
  logic [SIN_OFF_W-1:0]  sin_off_d, sin_off_q;

  assign phase_d = adv_i ? phase_q + step_i : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_comb begin
    quarter = phase_q[PHASE_BITS-1 -: 2];
    frac    = phase_q[PHASE_BITS-3 -: SIN_FRAC_W];
    // mirror the index on the falling quarters
    if (quarter[0]) begin
      idx = ROM_IDX_W'(SINE_DEPTH) - ROM_IDX_W'(frac);
    end else begin
      idx = ROM_IDX_W'(frac);
    end
    rom_val = SINE_ROM[idx];
    // sine + 1 in unsigned Q2.15, the sine negated on the lower half cycle
    if (quarter[1]) begin
      sin_off_d = SIN_BIAS - SIN_OFF_W'(rom_val);
    end else begin
      sin_off_d = SIN_BIAS + SIN_OFF_W'(rom_val);
    end
  end

  always_ff @(posedge clk_i) begin
    sin_off_q <= sin_off_d;
  end

  assign sin_off_o = sin_off_q;

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(phase_q))
    else $error("phase moved without an advance");

endmodule

// File: rtl/ttsd_ctrl.sv
// Sequencer that steps one item through the shared multiplier.
// Depends on ttsd_pkg for the state enum and the control struct.
module ttsd_ctrl import ttsd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  trem_on_i,
  input  logic  out_free_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_GAIN;
      ST_GAIN:   state_d = ST_XCLAMP;
      ST_XCLAMP: state_d = trem_on_i ? ST_WET : ST_SQ1;
      ST_WET:    state_d = ST_WETSH;
      ST_WETSH:  state_d = ST_MIX;
      ST_MIX:    state_d = ST_MIXSH;
      ST_MIXSH:  state_d = ST_SQ1;
      ST_SQ1:    state_d = ST_CUBE1;
      ST_CUBE1:  state_d = ST_LIN1;
      ST_LIN1:   state_d = ST_F1;
      ST_F1:     state_d = ST_SQ2;
      ST_SQ2:    state_d = ST_CUBE2;
      ST_CUBE2:  state_d = ST_DRV2;
      ST_DRV2:   state_d = ST_G;
      ST_G:      state_d = ST_OUT;
      ST_OUT:    if (out_free_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o         = '0;
    ctrl_o.mul_sel = MUL_GAIN;
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        ctrl_o.ld_s     = in_valid_i;
        ctrl_o.lfo_adv  = in_valid_i;
      end
      ST_GAIN:   ctrl_o.mul_sel = MUL_GAIN;
      ST_XCLAMP: ctrl_o.ld_x_gain = 1'b1;
      ST_WET:    ctrl_o.mul_sel = MUL_WET;
      ST_WETSH:  ctrl_o.ld_diff = 1'b1;
      ST_MIX:    ctrl_o.mul_sel = MUL_MIX;
      ST_MIXSH:  ctrl_o.ld_x_mix = 1'b1;
      ST_SQ1:    ctrl_o.mul_sel = MUL_XX;
      ST_CUBE1:  ctrl_o.mul_sel = MUL_SQX;
      ST_LIN1: begin
        ctrl_o.mul_sel = MUL_LIN;
        ctrl_o.ld_t    = 1'b1;
      end
      ST_F1:     ctrl_o.ld_f = 1'b1;
      ST_SQ2:    ctrl_o.mul_sel = MUL_FF;
      ST_CUBE2:  ctrl_o.mul_sel = MUL_SQF;
      ST_DRV2:   ctrl_o.mul_sel = MUL_DRV2;
      ST_G:      ctrl_o.ld_y = 1'b1;
      ST_OUT:    ctrl_o.ld_out = out_free_i;
      default:   ctrl_o.in_ready = 1'b0;
    endcase
  end

endmodule

// File: rtl/tremolo_two_stage_distortion_top.sv
// Every multiply goes through the one shared 33x33 multiplier, one product per cycle under
// the sequencer. A new item is taken only after the last reached the output register.
// With tremolo off (zero LFO step) the sequencer skips the tremolo states.
// A finished result waits in the output register while the next item is accepted.
// Reset (rst_ni low, asynchronous) clears the sequencer, the configuration registers,
// the output valid flag and the phase accumulator; datapath registers are not reset.
// Depends on ttsd_pkg, ttsd_mul, ttsd_lfo and ttsd_ctrl.
module tremolo_two_stage_distortion_top import ttsd_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o
);

  localparam logic signed [33:0] XG_MAX = 34'sd2147483647;
  localparam logic signed [33:0] XG_MIN = -34'sd2147483648;
  localparam logic signed [31:0] X_NEG4 = -32'sd1073741824;
  localparam logic signed [29:0] F_ONE  = 30'sd268435456;
  localparam logic signed [34:0] F_HI   = 35'sd268435456;
  localparam logic signed [35:0] G_HI   = 36'sd268435456;
  localparam logic signed [16:0] Y_MAX  = 17'sd32767;

  // configuration registers
  logic [15:0]           gain_q;
  logic [PHASE_BITS-1:0] step_q;
  logic [10:0]           depth_q;
  logic [11:0]           drive1_q;
  logic [11:0]           drive2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= '0;
      step_q   <= '0;
      depth_q  <= '0;
      drive1_q <= '0;
      drive2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INPUT_GAIN: gain_q   <= cfg_data_i[15:0];
        CFG_LFO_STEP:   step_q   <= cfg_data_i[PHASE_BITS-1:0];
        CFG_LFO_DEPTH:  depth_q  <= cfg_data_i[10:0];
        CFG_DRIVE1:     drive1_q <= cfg_data_i[11:0];
        CFG_DRIVE2:     drive2_q <= cfg_data_i[11:0];
        default:        ;
      endcase
    end
  end

  logic [10:0] d_sat;
  logic [11:0] d1_sat;
  logic [11:0] d2_sat;
  logic [12:0] d1x3;

  assign d_sat  = (depth_q > DEPTH_MAX) ? DEPTH_MAX : depth_q;
  assign d1_sat = (drive1_q > DRIVE_MAX) ? DRIVE_MAX : drive1_q;
  assign d2_sat = (drive2_q > DRIVE_MAX) ? DRIVE_MAX : drive2_q;
  assign d1x3   = 13'(d1_sat) + {d1_sat, 1'b0};

  // sequencer, LFO and multiplier
  ctrl_t                    ctrl;
  logic                     out_valid_q;
  logic                     out_free;
  logic [SIN_OFF_W-1:0]     sin_off;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  assign out_free = !out_valid_q || out_ready_i;

  ttsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .trem_on_i  (step_q != '0),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  ttsd_lfo u_lfo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (ctrl.lfo_adv),
    .step_i    (step_q),
    .sin_off_o (sin_off)
  );

  ttsd_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // datapath registers
  logic signed [SAMPLE_BITS-1:0] s_q;
  logic signed [31:0]            x_q;
  logic signed [MUL_W-1:0]       diff_q;
  logic signed [34:0]            t_q;
  logic signed [29:0]            f_q;
  logic signed [SAMPLE_BITS-1:0] y_q;
  logic signed [SAMPLE_BITS-1:0] out_q;

  // previous product shifted down by 28, used as the next operand
  logic signed [MUL_W-1:0] prod_sh28;
  assign prod_sh28 = prod[60:28];

  always_comb begin
    mul_a = MUL_W'(s_q);
    mul_b = $signed(MUL_W'(gain_q));
    case (ctrl.mul_sel)
      MUL_GAIN: begin
        mul_a = MUL_W'(s_q);
        mul_b = $signed(MUL_W'(gain_q));
      end
      MUL_WET: begin
        mul_a = MUL_W'(x_q);
        mul_b = $signed(MUL_W'(sin_off));
      end
      MUL_MIX: begin
        mul_a = diff_q;
        mul_b = $signed(MUL_W'(d_sat));
      end
      MUL_XX: begin
        mul_a = MUL_W'(x_q);
        mul_b = MUL_W'(x_q);
      end
      MUL_SQX: begin
        mul_a = prod_sh28;
        mul_b = MUL_W'(x_q);
      end
      MUL_LIN: begin
        mul_a = MUL_W'(x_q);
        mul_b = $signed(MUL_W'(d1x3));
      end
      MUL_FF: begin
        mul_a = MUL_W'(f_q);
        mul_b = MUL_W'(f_q);
      end
      MUL_SQF: begin
        mul_a = prod_sh28;
        mul_b = MUL_W'(f_q);
      end
      MUL_DRV2: begin
        mul_a = prod_sh28;
        mul_b = $signed(MUL_W'(d2_sat));
      end
      default: begin
        mul_a = MUL_W'(s_q);
        mul_b = $signed(MUL_W'(gain_q));
      end
    endcase
  end

  // input gain into Q4.28, saturated
  logic signed [33:0] xg_wide;
  logic signed [31:0] x_gain_d;
  assign xg_wide = {prod[32:0], 1'b0};
  always_comb begin
    if (xg_wide > XG_MAX) begin
      x_gain_d = 32'(XG_MAX);
    end else if (xg_wide < XG_MIN) begin
      x_gain_d = 32'(XG_MIN);
    end else begin
      x_gain_d = xg_wide[31:0];
    end
  end

  // tremolo: wet minus dry, then dry plus the depth-scaled difference
  logic signed [MUL_W-1:0] diff_d;
  logic signed [31:0]      x_mix_d;
  assign diff_d  = $signed(prod[48:16]) - MUL_W'(x_q);
  assign x_mix_d = x_q + $signed(prod[41:10]);

  // first stage: linear term minus half the cube, or the clipped value for |x| >= 4
  logic               x_ge4, x_le4;
  logic signed [33:0] lin1, half1;
  logic signed [34:0] f_raw;
  logic signed [29:0] f_d;
  assign x_ge4 = !x_q[31] && x_q[30];
  assign x_le4 = (x_q <= X_NEG4);
  assign lin1  = prod[43:10];
  assign half1 = t_q[34:1];
  assign f_raw = 35'(lin1) - 35'(half1);
  always_comb begin
    if (x_ge4) begin
      f_d = -F_ONE;
    end else if (x_le4) begin
      f_d = F_ONE;
    end else if (f_raw > F_HI) begin
      f_d = F_ONE;
    end else if (f_raw < -F_HI) begin
      f_d = -F_ONE;
    end else begin
      f_d = f_raw[29:0];
    end
  end

  // second stage and conversion to Q1.15
  logic signed [33:0] drv2;
  logic signed [30:0] f2;
  logic signed [35:0] f3, g_raw;
  logic signed [29:0] g;
  logic signed [16:0] y_wide;
  logic signed [SAMPLE_BITS-1:0] y_d;
  assign drv2  = prod[40:7];
  assign f2    = {f_q, 1'b0};
  assign f3    = 36'(f_q) + 36'(f2);
  assign g_raw = 36'(drv2) - f3;
  always_comb begin
    if (g_raw > G_HI) begin
      g = F_ONE;
    end else if (g_raw < -G_HI) begin
      g = -F_ONE;
    end else begin
      g = g_raw[29:0];
    end
    y_wide = g[29:13];
    y_d    = (y_wide > Y_MAX) ? Y_MAX[SAMPLE_BITS-1:0] : y_wide[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_s)      s_q    <= sample_in_i;
    if (ctrl.ld_x_gain) x_q    <= x_gain_d;
    if (ctrl.ld_x_mix)  x_q    <= x_mix_d;
    if (ctrl.ld_diff)   diff_q <= diff_d;
    if (ctrl.ld_t)      t_q    <= prod[62:28];
    if (ctrl.ld_f)      f_q    <= f_d;
    if (ctrl.ld_y)      y_q    <= y_d;
    if (ctrl.ld_out)    out_q  <= y_q;
  end

  // output register: hold the item until taken
  logic out_valid_d;
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.ld_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o   = ctrl.in_ready;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready stayed high after an item was accepted");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ld_out |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_f_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.mul_sel == MUL_FF) |-> (f_q <= F_ONE && f_q >= -F_ONE))
    else $error("first stage output outside +-1");

endmodule

// File: sim/tremolo_two_stage_distortion_checker.sv
// Checker for the tremolo/drive block: tracks the register port and the sample channels,
// predicts every processed sample and compares it with the block's output.
// Depends on ttsd_pkg for the register indexes and the sample width.
module tremolo_two_stage_distortion_checker import ttsd_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_out_i,
  output int                            mismatches_o,
  output int                            pending_o,
  output int                            checked_o
);

  localparam longint          ONE_Q28    = 64'sd268435456;
  localparam longint          X_MAX      = 64'sd2147483647;
  localparam longint          X_MIN      = -64'sd2147483648;
  localparam longint          DEPTH_FULL = 64'sd1024;
  localparam longint          DRIVE_TOP  = 64'sd2560;
  localparam longint unsigned PI_Q2_30   = 64'd3373259426;
  localparam int              QTR_STEPS  = 256;

  logic [15:0] input_gain_q;
  logic [23:0] lfo_step_q;
  logic [23:0] lfo_phase_q;
  logic [10:0] lfo_depth_q;
  logic [11:0] drive1_q;
  logic [11:0] drive2_q;

  longint                        sine_tbl [QTR_STEPS+1];
  logic signed [SAMPLE_BITS-1:0] expected_samples [$];
  logic signed [SAMPLE_BITS-1:0] want;

  // round(sin(k*pi/512) * 32768) from a Taylor series in Q2.30
  function automatic longint sine_magnitude(int k);
    longint unsigned ang;
    longint unsigned term;
    longint          acc;
    longint          r;
    ang  = (64'(k) * PI_Q2_30) / (2 * QTR_STEPS);
    term = ang;
    acc  = $signed(ang);
    for (int i = 1; i <= 7; i++) begin
      term = (term * ang) >> 30;
      term = (term * ang) >> 30;
      term = term / 64'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    r = (acc + 64'sd16384) >>> 15;
    if (r < 0) begin
      r = 0;
    end else if (r > 64'sd32768) begin
      r = 64'sd32768;
    end
    return r;
  endfunction

  initial begin
    for (int k = 0; k <= QTR_STEPS; k++) begin
      sine_tbl[k] = sine_magnitude(k);
    end
  end

  // Advances the phase and returns the processed sample.
  function automatic logic signed [15:0] shape_sample(logic signed [15:0] smp);
    longint x, wet, sine, d, d1, d2, f, g, sq, cube, y;
    int     idx;
    x = longint'(smp) * longint'(input_gain_q) * 2;
    if (x > X_MAX) begin
      x = X_MAX;
    end else if (x < X_MIN) begin
      x = X_MIN;
    end

    // the phase moves before the sine is looked up
    lfo_phase_q = lfo_phase_q + lfo_step_q;
    if (lfo_step_q != '0) begin
      idx = int'(lfo_phase_q[21:14]);
      if (lfo_phase_q[22]) begin
        idx = QTR_STEPS - idx;
      end
      sine = sine_tbl[idx];
      if (lfo_phase_q[23]) begin
        sine = -sine;
      end
      wet = (x * (sine + 64'sd32768)) >>> 16;
      d   = (lfo_depth_q > DEPTH_FULL) ? DEPTH_FULL : longint'(lfo_depth_q);
      x   = (wet * d + x * (DEPTH_FULL - d)) >>> 10;
    end

    d1 = (drive1_q > DRIVE_TOP) ? DRIVE_TOP : longint'(drive1_q);
    if (x >= 4 * ONE_Q28) begin
      f = -ONE_Q28;
    end else if (x <= -4 * ONE_Q28) begin
      f = ONE_Q28;
    end else begin
      sq   = (x * x) >>> 28;
      cube = (sq * x) >>> 28;
      f    = ((x * d1 * 3) >>> 10) - (cube >>> 1);
      if (f > ONE_Q28) begin
        f = ONE_Q28;
      end else if (f < -ONE_Q28) begin
        f = -ONE_Q28;
      end
    end

    d2   = (drive2_q > DRIVE_TOP) ? DRIVE_TOP : longint'(drive2_q);
    sq   = (f * f) >>> 28;
    cube = (sq * f) >>> 28;
    g    = ((cube * d2) >>> 7) - 3 * f;
    if (g > ONE_Q28) begin
      g = ONE_Q28;
    end else if (g < -ONE_Q28) begin
      g = -ONE_Q28;
    end

    y = g >>> 13;
    if (y > 64'sd32767) begin
      y = 64'sd32767;
    end else if (y < -64'sd32768) begin
      y = -64'sd32768;
    end
    return y[15:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_gain_q = '0;
      lfo_step_q   = '0;
      lfo_phase_q  = '0;
      lfo_depth_q  = '0;
      drive1_q     = '0;
      drive2_q     = '0;
      expected_samples.delete();
      mismatches_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_INPUT_GAIN: input_gain_q = cfg_data_i[15:0];
          CFG_LFO_STEP:   lfo_step_q   = cfg_data_i[23:0];
          CFG_LFO_DEPTH:  lfo_depth_q  = cfg_data_i[10:0];
          CFG_DRIVE1:     drive1_q     = cfg_data_i[11:0];
          CFG_DRIVE2:     drive2_q     = cfg_data_i[11:0];
          default: ;
        endcase
      end

      // retire the oldest prediction before queuing a new one
      if (out_valid_i && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          mismatches_o++;
          $display("%0t: sample_out %0d with no sample pending", $time, sample_out_i);
        end else begin
          want = expected_samples.pop_front();
          checked_o++;
          if (sample_out_i !== want) begin
            mismatches_o++;
            $display("%0t: sample_out expected %0d, got %0d", $time, want, sample_out_i);
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        expected_samples.push_back(shape_sample(sample_in_i));
      end
      pending_o = expected_samples.size();
    end
  end

endmodule

// File: sim/tremolo_two_stage_distortion_top_tb.sv
// Testbench top for the tremolo/drive block: clock, reset, register loads and sample
// traffic with random idling on both channels; the checker beside the block compares.
// Depends on ttsd_pkg, tremolo_two_stage_distortion_top and the checker module.
module tremolo_two_stage_distortion_top_tb;
  import ttsd_pkg::*;

  localparam int RAND_PHASES     = 10;
  localparam int ITEMS_PER_PHASE = 113;
  localparam int DRAIN_SLACK     = 16;

  localparam logic signed [15:0] PLAIN_SAMPLES [7] =
    '{16'sd0, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1, 16'sd16384, -16'sd16384};
  localparam logic signed [15:0] HOT_SAMPLES [8] =
    '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd8192, -16'sd8192,
      16'sd0, 16'sd3};
  localparam logic signed [15:0] WRAP_SAMPLES [7] =
    '{16'sd20000, -16'sd20000, 16'sd4000, -16'sd4000, 16'sd100, -16'sd100, 16'sd32767};

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [CFG_IDX_W-1:0]          cfg_idx;
  logic [CFG_DATA_W-1:0]         cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  int mismatches;
  int pending;
  int checked;
  int items_sent;
  int settings_loaded;
  bit steady;

  tremolo_two_stage_distortion_top i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .sample_in_i  (sample_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .sample_out_o (sample_out)
  );

  tremolo_two_stage_distortion_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .sample_in_i  (sample_in),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .sample_out_i (sample_out),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #5 clk = ~clk;

  // Called at a falling edge with the block idle.
  task automatic load_settings(input logic [15:0] gain, input logic [23:0] step,
                               input logic [10:0] depth, input logic [11:0] drv1,
                               input logic [11:0] drv2);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_INPUT_GAIN;
    cfg_data <= CFG_DATA_W'(gain);
    @(negedge clk);
    cfg_idx  <= CFG_LFO_STEP;
    cfg_data <= step;
    @(negedge clk);
    cfg_idx  <= CFG_LFO_DEPTH;
    cfg_data <= CFG_DATA_W'(depth);
    @(negedge clk);
    cfg_idx  <= CFG_DRIVE1;
    cfg_data <= CFG_DATA_W'(drv1);
    @(negedge clk);
    cfg_idx  <= CFG_DRIVE2;
    cfg_data <= CFG_DATA_W'(drv2);
    @(negedge clk);
    cfg_we   <= 1'b0;
    settings_loaded++;
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_sample(input logic signed [15:0] value);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 45) begin
      gap = 0;
    end else if (r < 90) begin
      gap = $urandom_range(1, 3);
    end else if (r < 98) begin
      gap = $urandom_range(4, 12);
    end else begin
      gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= value;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Hold the sender until every predicted sample has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  function automatic logic [11:0] pick_drive();
    case ($urandom_range(0, 5))
      0:       return 12'd0;
      1:       return 12'd2560;
      2:       return 12'($urandom_range(2561, 4095));
      default: return 12'($urandom_range(0, 2560));
    endcase
  endfunction

  initial begin
    int hi;
    int lo;
    out_ready = 1'b0;
    forever begin
      case ($urandom_range(0, 9))
        0: begin
          hi = $urandom_range(100, 300);
          lo = 1;
        end
        1: begin
          hi = $urandom_range(1, 4);
          lo = $urandom_range(15, 60);
        end
        default: begin
          hi = $urandom_range(1, 8);
          lo = $urandom_range(1, 3);
        end
      endcase
      @(negedge clk);
      out_ready <= 1'b1;
      repeat (hi) @(negedge clk);
      out_ready <= 1'b0;
      repeat (lo - 1) @(negedge clk);
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL tremolo_two_stage_distortion_top");
    $finish;
  end

  initial begin
    logic [15:0]        gain;
    logic [23:0]        step;
    logic [10:0]        depth;
    logic signed [15:0] smp;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_INPUT_GAIN;
    cfg_data        = '0;
    in_valid        = 1'b0;
    sample_in       = '0;
    items_sent      = 0;
    settings_loaded = 0;
    steady          = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // unity gain, tremolo off, light drive
    load_settings(16'd4096, 24'd0, 11'd0, 12'd256, 12'd256);
    foreach (PLAIN_SAMPLES[i]) send_sample(PLAIN_SAMPLES[i]);

    // full gain into saturation, quarter-cycle phase steps, full depth and drive
    wait_drained();
    load_settings(16'd65535, 24'h400000, 11'd1024, 12'd2560, 12'd2560);
    foreach (HOT_SAMPLES[i]) send_sample(HOT_SAMPLES[i]);

    // phase wraps every item; depth and drives above their ranges
    wait_drained();
    load_settings(16'd8192, 24'hFFFFFF, 11'd2047, 12'd4095, 12'd4095);
    foreach (WRAP_SAMPLES[i]) send_sample(WRAP_SAMPLES[i]);

    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_drained();
      case ($urandom_range(0, 5))
        0:       gain = 16'd0;
        1:       gain = 16'd65535;
        2:       gain = 16'd4096;
        default: gain = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       step = 24'd0;
        1:       step = 24'hFFFFFF;
        2:       step = 24'($urandom_range(1, 255));
        3:       step = 24'h400000;
        default: step = 24'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       depth = 11'd0;
        1:       depth = 11'd1024;
        2:       depth = 11'($urandom_range(1025, 2047));
        default: depth = 11'($urandom_range(0, 1024));
      endcase
      load_settings(gain, step, depth, pick_drive(), pick_drive());
      steady = ($urandom_range(0, 3) == 0);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2 && (p == 0 || $urandom_range(0, 2) == 0)) begin
          wait_drained();
        end
        case ($urandom_range(0, 9))
          0:       smp = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
          1:       smp = 16'($urandom_range(0, 127) - 64);
          default: smp = 16'($urandom);
        endcase
        send_sample(smp);
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (DRAIN_SLACK) @(negedge clk);
    $display("Sent %0d samples under %0d register settings; %0d outputs compared.",
             items_sent, settings_loaded, checked);
    $display("Covered tremolo on and off, phase wrap, gain saturation and both clip stages.");
    if (mismatches == 0 && pending == 0) begin
      $display("PASS tremolo_two_stage_distortion_top");
    end else begin
      $display("FAIL tremolo_two_stage_distortion_top");
    end
    $finish;
  end

endmodule
